// ===== hdl/sprite_blitter_key_alpha_defines.svh =====
// assertion macros used by the blitter FIFO module
`ifndef SPRITE_BLITTER_KEY_ALPHA_DEFINES_SVH
`define SPRITE_BLITTER_KEY_ALPHA_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define SBKA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define SBKA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/sbka_pkg.sv =====
`timescale 1ns / 1ps

package sbka_pkg;

    localparam int QUEUE_AW = 2;
    localparam int CFG_IW   = 3;
    localparam int CFG_DW   = 24;

    localparam logic [CFG_IW-1:0] REG_PLACE_X    = 3'd0;
    localparam logic [CFG_IW-1:0] REG_PLACE_Y    = 3'd1;
    localparam logic [CFG_IW-1:0] REG_IMG_WIDTH  = 3'd2;
    localparam logic [CFG_IW-1:0] REG_IMG_HEIGHT = 3'd3;
    localparam logic [CFG_IW-1:0] REG_BLIT_MODE  = 3'd4;
    localparam logic [CFG_IW-1:0] REG_KEY_VALUE  = 3'd5;
    localparam logic [CFG_IW-1:0] REG_FILL_COLOR = 3'd6;

    localparam logic [2:0] MODE_COPY   = 3'd0;
    localparam logic [2:0] MODE_KEYED  = 3'd1;
    localparam logic [2:0] MODE_MIRROR = 3'd2;
    localparam logic [2:0] MODE_ALPHA  = 3'd3;
    localparam logic [2:0] MODE_FILL   = 3'd4;

    typedef struct packed {
        logic [7:0] src_red;
        logic [7:0] src_green;
        logic [7:0] src_blue;
        logic [7:0] src_alpha;
        logic [7:0] dst_red;
        logic [7:0] dst_green;
        logic [7:0] dst_blue;
    } t_pixel;

    typedef struct packed {
        logic [8:0] write_x;
        logic [7:0] write_y;
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
    } t_write;

    // classified pixel waiting for the blend unit
    typedef struct packed {
        logic [8:0] write_x;
        logic [7:0] write_y;
        logic [7:0] alpha;
        logic [7:0] s_red;
        logic [7:0] s_green;
        logic [7:0] s_blue;
        logic [7:0] d_red;
        logic [7:0] d_green;
        logic [7:0] d_blue;
    } t_job;

endpackage

// ===== hdl/sbka_fifo.sv =====
`timescale 1ns / 1ps
`include "sprite_blitter_key_alpha_defines.svh"

module sbka_fifo #(
    parameter type t_item = logic
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_data,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_item o_data
);

    localparam int AW    = sbka_pkg::QUEUE_AW;
    localparam int DEPTH = 1 << AW;

    t_item         r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    `SBKA_ASSERT_NEXT(a_cnt_up, i_clk, i_rst_n, do_push && !do_pop, r_cnt == $past(r_cnt) + 1'b1, "fifo count did not rise on push")
    `SBKA_ASSERT_NEXT(a_cnt_down, i_clk, i_rst_n, do_pop && !do_push, r_cnt == $past(r_cnt) - 1'b1, "fifo count did not fall on pop")
    `SBKA_ASSERT_NOW(a_ptr_gap, i_clk, i_rst_n, !o_full && !o_empty, (r_wp - r_rp) == r_cnt[AW-1:0], "fifo pointers disagree with count")

endmodule

// ===== hdl/sbka_front.sv =====
`timescale 1ns / 1ps

module sbka_front #(
    parameter int FB_WIDTH       = 512,
    parameter int FB_HEIGHT      = 256,
    parameter int MAX_IMAGE_SIDE = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [sbka_pkg::CFG_IW-1:0]   i_cfg_index,
    input  logic [sbka_pkg::CFG_DW-1:0]   i_cfg_data,
    input  logic                          i_accept,
    input  sbka_pkg::t_pixel              i_pixel,
    output logic                          o_job_push,
    output sbka_pkg::t_job                o_job
);

    localparam int SizeLimInt = (MAX_IMAGE_SIDE < 256) ? MAX_IMAGE_SIDE : 256;
    localparam logic [8:0]         SizeLim = 9'(SizeLimInt);
    localparam logic signed [13:0] FbW     = 14'(FB_WIDTH);
    localparam logic signed [13:0] FbH     = 14'(FB_HEIGHT);

    logic [11:0] r_place_x, r_place_y;
    logic [8:0]  r_width, r_height;
    logic [2:0]  r_mode;
    logic [7:0]  r_key;
    logic [23:0] r_fill;
    logic [7:0]  r_col, r_row;

    logic [8:0]         w, h;
    logic signed [13:0] cx, tx, ty;
    logic               keyed, clipped, emit, col_wrap, row_wrap;

    function automatic logic [8:0] eff_size(input logic [8:0] v);
        logic [8:0] r;
        r = v;
        if (v == '0) begin
            r = 9'd1;
        end else if (v > SizeLim) begin
            r = SizeLim;
        end
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_place_x <= '0;
            r_place_y <= '0;
            r_width   <= 9'd16;
            r_height  <= 9'd16;
            r_mode    <= sbka_pkg::MODE_COPY;
            r_key     <= '0;
            r_fill    <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                sbka_pkg::REG_PLACE_X:    r_place_x <= i_cfg_data[11:0];
                sbka_pkg::REG_PLACE_Y:    r_place_y <= i_cfg_data[11:0];
                sbka_pkg::REG_IMG_WIDTH:  r_width   <= i_cfg_data[8:0];
                sbka_pkg::REG_IMG_HEIGHT: r_height  <= i_cfg_data[8:0];
                sbka_pkg::REG_BLIT_MODE:  r_mode    <= i_cfg_data[2:0];
                sbka_pkg::REG_KEY_VALUE:  r_key     <= i_cfg_data[7:0];
                sbka_pkg::REG_FILL_COLOR: r_fill    <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w  = eff_size(r_width);
        h  = eff_size(r_height);
        if (r_mode == sbka_pkg::MODE_MIRROR) begin
            cx = $signed(14'(w)) - 14'sd1 - $signed(14'(r_col));
        end else begin
            cx = $signed(14'(r_col));
        end
        tx = $signed({{2{r_place_x[11]}}, r_place_x}) + cx;
        ty = $signed({{2{r_place_y[11]}}, r_place_y}) + $signed(14'(r_row));
        clipped = (tx < 14'sd0) || (tx >= FbW) || (ty < 14'sd0) || (ty >= FbH);
        keyed   = (i_pixel.src_red == r_key) && (i_pixel.src_green == r_key)
                  && (i_pixel.src_blue == r_key);

        o_job.write_x = tx[8:0];
        o_job.write_y = ty[7:0];
        o_job.d_red   = i_pixel.dst_red;
        o_job.d_green = i_pixel.dst_green;
        o_job.d_blue  = i_pixel.dst_blue;
        o_job.s_red   = i_pixel.src_red;
        o_job.s_green = i_pixel.src_green;
        o_job.s_blue  = i_pixel.src_blue;
        // full opacity turns the blend into a plain copy
        o_job.alpha   = 8'hff;
        emit          = 1'b0;
        case (r_mode)
            sbka_pkg::MODE_COPY: begin
                emit = 1'b1;
            end
            sbka_pkg::MODE_KEYED, sbka_pkg::MODE_MIRROR: begin
                emit = !keyed;
            end
            sbka_pkg::MODE_ALPHA: begin
                emit        = 1'b1;
                o_job.alpha = i_pixel.src_alpha;
            end
            sbka_pkg::MODE_FILL: begin
                emit          = 1'b1;
                o_job.alpha   = i_pixel.src_alpha;
                o_job.s_red   = r_fill[23:16];
                o_job.s_green = r_fill[15:8];
                o_job.s_blue  = r_fill[7:0];
            end
            default: begin
                emit = 1'b0;
            end
        endcase
        o_job_push = i_accept && emit && !clipped;
        col_wrap   = ({1'b0, r_col} + 9'd1) >= w;
        row_wrap   = ({1'b0, r_row} + 9'd1) >= h;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_accept) begin
            if (col_wrap) begin
                r_col <= '0;
                r_row <= row_wrap ? 8'd0 : r_row + 8'd1;
            end else begin
                r_col <= r_col + 8'd1;
            end
        end
    end

endmodule

// ===== hdl/sbka_back.sv =====
`timescale 1ns / 1ps

module sbka_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_job_empty,
    input  sbka_pkg::t_job   i_job,
    output logic             o_job_pop,
    input  logic             i_out_full,
    output logic             o_out_push,
    output sbka_pkg::t_write o_out
);

    typedef struct packed {
        logic [8:0]  write_x;
        logic [7:0]  write_y;
        logic [15:0] sum_red;
        logic [15:0] sum_green;
        logic [15:0] sum_blue;
    } t_sum;

    t_sum r_s1;
    logic r_s1_valid;
    logic en;
    t_sum n_s1;

    function automatic logic [15:0] mix(input logic [7:0] d, input logic [7:0] s,
                                        input logic [7:0] a);
        logic [7:0] inv_a;
        inv_a = 8'hff - a;
        return 16'(d) * 16'(inv_a) + 16'(s) * 16'(a);
    endfunction

    // exact divide by 255 for sums up to 65279
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = 17'(x) + 17'd1 + 17'(x[15:8]);
        return t[15:8];
    endfunction

    assign en         = !r_s1_valid || !i_out_full;
    assign o_job_pop  = en && !i_job_empty;
    assign o_out_push = r_s1_valid && !i_out_full;

    always_comb begin
        n_s1.write_x   = i_job.write_x;
        n_s1.write_y   = i_job.write_y;
        n_s1.sum_red   = mix(i_job.d_red, i_job.s_red, i_job.alpha);
        n_s1.sum_green = mix(i_job.d_green, i_job.s_green, i_job.alpha);
        n_s1.sum_blue  = mix(i_job.d_blue, i_job.s_blue, i_job.alpha);

        o_out.write_x   = r_s1.write_x;
        o_out.write_y   = r_s1.write_y;
        o_out.out_red   = div255(r_s1.sum_red);
        o_out.out_green = div255(r_s1.sum_green);
        o_out.out_blue  = div255(r_s1.sum_blue);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= !i_job_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1 <= n_s1;
        end
    end

endmodule

// ===== hdl/sprite_blitter_key_alpha.sv =====
`timescale 1ns / 1ps
// channel   direction  handshake            payload
// pixel     in         push / full          i_pixel (t_pixel)
// write     out        pop / empty          o_write (t_write)
// config    in         i_cfg_valid / ready  i_cfg_index, i_cfg_data
//
// one pixel per clock sustained while full is low; pixels pass through the
// job queue, the product register in the blend unit and the output queue
// four-entry queues sit between front and blend and at the output
// synchronous active-low reset clears counters, queues and config to defaults
// clipped, keyed or unused-mode pixels advance the counters and write nothing

module sprite_blitter_key_alpha #(
    parameter int FB_WIDTH       = 512,
    parameter int FB_HEIGHT      = 256,
    parameter int MAX_IMAGE_SIDE = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  sbka_pkg::t_pixel            i_pixel,
    output logic                        empty,
    input  logic                        pop,
    output sbka_pkg::t_write            o_write,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [sbka_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [sbka_pkg::CFG_DW-1:0] i_cfg_data
);

    logic             accept;
    logic             job_push, job_full, job_pop, job_empty;
    sbka_pkg::t_job   job_in, job_out;
    logic             out_push, out_full;
    sbka_pkg::t_write out_data;

    assign o_cfg_ready = 1'b1;
    assign full        = job_full;
    assign accept      = push && !job_full;

    sbka_front #(
        .FB_WIDTH       (FB_WIDTH),
        .FB_HEIGHT      (FB_HEIGHT),
        .MAX_IMAGE_SIDE (MAX_IMAGE_SIDE)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_pixel     (i_pixel),
        .o_job_push  (job_push),
        .o_job       (job_in)
    );

    sbka_fifo #(
        .t_item (sbka_pkg::t_job)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_empty (job_empty),
        .o_data  (job_out)
    );

    sbka_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (job_empty),
        .i_job       (job_out),
        .o_job_pop   (job_pop),
        .i_out_full  (out_full),
        .o_out_push  (out_push),
        .o_out       (out_data)
    );

    sbka_fifo #(
        .t_item (sbka_pkg::t_write)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_data),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (o_write)
    );

endmodule
